// ----- hdl/bvm_pkg.sv -----
// Shared types and constants for the battery voltage monitor.
// Holds the transaction payload structs, register map and fixed field widths.
// No dependencies.
`default_nettype none

package bvm_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W   = 12;
  localparam int MV_W       = 16;
  localparam int CFG_W      = 16;
  localparam int FRAC_SH    = 12;
  localparam int MVP_W      = SAMPLE_W + CFG_W;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // Register reset values.
  localparam logic [CFG_W-1:0] FULL_SCALE_RST = 16'd9000;
  localparam logic [CFG_W-1:0] THR_RUN_RST    = 16'd6800;
  localparam logic [CFG_W-1:0] THR_IDLE_RST   = 16'd7000;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_FULL_SCALE = 2'd0,
    REG_THR_RUN    = 2'd1,
    REG_THR_IDLE   = 2'd2
  } reg_idx_e;

  // Input transaction payload.
  typedef struct packed {
    logic [SAMPLE_W-1:0] adc_sample;
    logic                sys_running;
  } in_t;

  // Output transaction payload.
  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered_value;
    logic [MV_W-1:0]     battery_mv;
    logic                battery_low;
  } out_t;

  // Per-item status handed from the ring stage to the scaling pipeline.
  typedef struct packed {
    logic                filled;
    logic [SAMPLE_W-1:0] first_sample;
    logic                sys_running;
  } ring_info_t;

  // Configuration register values.
  typedef struct packed {
    logic [CFG_W-1:0] full_scale_mv;
    logic [CFG_W-1:0] thr_run_mv;
    logic [CFG_W-1:0] thr_idle_mv;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/bvm_ring.sv -----
// Sample ring memory and running-total update for the battery voltage monitor.
// Reads the oldest sample at acceptance, replaces it when the item leaves the ring stage.
// Depends on bvm_pkg.
`default_nettype none

module bvm_ring
  import bvm_pkg::*;
#(
  parameter int WINDOW_LEN = 16,
  localparam int PTR_W = $clog2(WINDOW_LEN),
  localparam int SUM_W = SAMPLE_W + PTR_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_t              in_data_i,
  output logic                  dn_valid_o,
  input  wire logic             dn_stall_i,
  output logic [SUM_W-1:0]      dn_total_o,
  output ring_info_t            dn_info_o
);

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW_LEN - 1);
  localparam logic [SUM_W-1:0] TOTAL_MAX = SUM_W'(((1 << SAMPLE_W) - 1) * WINDOW_LEN);

  logic [SAMPLE_W-1:0] ring_mem [WINDOW_LEN];
  logic [SAMPLE_W-1:0] rd_q;

  logic [PTR_W-1:0]    wp_q, wp_d;
  logic                v1_q;
  logic [SAMPLE_W-1:0] sample1_q;
  logic                run1_q;
  logic [PTR_W-1:0]    slot1_q;
  logic [SUM_W-1:0]    total_q, total_d;
  logic                filled_q, filled_d;
  logic [SAMPLE_W-1:0] first_q, first_d;
  logic                have_first_q;
  logic [SAMPLE_W-1:0] old_val;
  logic                accept;
  logic                fire1;

  // Handshake: the stage holding the read data is the only one here.
  assign in_stall_o = v1_q && dn_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign fire1      = v1_q && !dn_stall_i;

  // Slots are written in order from zero, so a slot holds data only once the ring has filled.
  assign old_val  = filled_q ? rd_q : '0;
  assign total_d  = total_q - SUM_W'(old_val) + SUM_W'(sample1_q);
  assign filled_d = filled_q || (slot1_q == LAST_SLOT);
  assign first_d  = have_first_q ? first_q : sample1_q;
  assign wp_d     = (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;

  // Results for the scaling pipeline.
  assign dn_valid_o = v1_q;
  assign dn_total_o = total_d;
  always_comb begin
    dn_info_o.filled       = filled_d;
    dn_info_o.first_sample = first_d;
    dn_info_o.sys_running  = run1_q;
  end

  // Ring memory: read at acceptance, write back when the item leaves.
  always_ff @(posedge clk_i) begin
    if (fire1) begin
      ring_mem[slot1_q] <= sample1_q;
    end
    if (accept) begin
      rd_q <= ring_mem[wp_q];
    end
  end

  // Payload of the item waiting on its read data.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample1_q <= in_data_i.adc_sample;
      run1_q    <= in_data_i.sys_running;
      slot1_q   <= wp_q;
    end
  end

  // Control state and running total.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      v1_q         <= 1'b0;
      total_q      <= '0;
      filled_q     <= 1'b0;
      first_q      <= '0;
      have_first_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        v1_q <= in_valid_i;
      end
      if (accept) begin
        wp_q <= wp_d;
      end
      if (fire1) begin
        total_q      <= total_d;
        filled_q     <= filled_d;
        first_q      <= first_d;
        have_first_q <= 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted transaction did not reach the ring stage");

  a_filled_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q |=> filled_q)
    else $error("ring fill flag cleared");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOTAL_MAX)
    else $error("running total exceeds the window maximum");

  // Before the first transaction leaves, at most that one has been accepted.
  a_first_before_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !have_first_q |-> (!filled_q && wp_q == PTR_W'(v1_q) && total_q == '0))
    else $error("ring state advanced before the first sample");
`endif

endmodule

`default_nettype wire

// ----- hdl/bvm_scale.sv -----
// Averaging, millivolt scaling and threshold compare for the battery voltage monitor.
// Four-stage pipeline with per-stage valid bits; bubbles close up under stall.
// Depends on bvm_pkg.
`default_nettype none

module bvm_scale
  import bvm_pkg::*;
#(
  parameter int WINDOW_LEN = 16,
  localparam int PTR_W = $clog2(WINDOW_LEN),
  localparam int SUM_W = SAMPLE_W + PTR_W
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             up_valid_i,
  output logic                  up_stall_o,
  input  wire logic [SUM_W-1:0] up_total_i,
  input  wire ring_info_t       up_info_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_t                  out_data_o
);

  // Division by the window length as a multiply by a rounded-up reciprocal.
  localparam int QSH  = SUM_W + PTR_W;
  localparam int QP_W = 2 * SUM_W + 1;
  localparam logic [SUM_W:0] RECIP =
    (SUM_W + 1)'(((longint'(1) << QSH) + WINDOW_LEN - 1) / WINDOW_LEN);

  logic va_q, vb_q, vc_q, vd_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  logic [SUM_W-1:0]    total_a_q;
  ring_info_t          info_a_q;
  logic [QP_W-1:0]     quot_b_q;
  ring_info_t          info_b_q;
  logic [SAMPLE_W-1:0] filt_c_q;
  logic [MVP_W-1:0]    mvp_c_q;
  logic                run_c_q;
  out_t                out_q;

  logic [SAMPLE_W-1:0] filt_b;
  logic [MV_W-1:0]     mv_c;
  logic [CFG_W-1:0]    thr_c;

  // Ready chain from the output register back to the input.
  assign rdy_d      = !vd_q || !out_stall_i;
  assign rdy_c      = !vc_q || rdy_d;
  assign rdy_b      = !vb_q || rdy_c;
  assign rdy_a      = !va_q || rdy_b;
  assign up_stall_o = !rdy_a;

  // Average before fill is the first sample.
  assign filt_b = info_b_q.filled ? quot_b_q[QSH +: SAMPLE_W] : info_b_q.first_sample;

  // Millivolts and the threshold chosen by the run flag.
  assign mv_c  = mvp_c_q[FRAC_SH +: MV_W];
  assign thr_c = run_c_q ? cfg_i.thr_run_mv : cfg_i.thr_idle_mv;

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (rdy_a && up_valid_i) begin
      total_a_q <= up_total_i;
      info_a_q  <= up_info_i;
    end
    if (rdy_b && va_q) begin
      quot_b_q <= QP_W'(total_a_q) * QP_W'(RECIP);
      info_b_q <= info_a_q;
    end
    if (rdy_c && vb_q) begin
      filt_c_q <= filt_b;
      mvp_c_q  <= MVP_W'(filt_b) * MVP_W'(cfg_i.full_scale_mv);
      run_c_q  <= info_b_q.sys_running;
    end
    if (rdy_d && vc_q) begin
      out_q.filtered_value <= filt_c_q;
      out_q.battery_mv     <= mv_c;
      out_q.battery_low    <= (mv_c < thr_c);
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= up_valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
      if (rdy_c) begin
        vc_q <= vb_q;
      end
      if (rdy_d) begin
        vd_q <= vc_q;
      end
    end
  end

  assign out_valid_o = vd_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- hdl/battery_voltage_monitor.sv -----
// Top level of the battery voltage monitor: register port, sample ring, scaling pipeline.
// Instantiates bvm_ring and bvm_scale; depends on bvm_pkg.
//
//   Channel  Direction  Handshake             Payload
//   in       sink       in_valid_i/in_stall_o  in_t  {adc_sample, sys_running}
//   out      source     out_valid_o/out_stall_i out_t {filtered_value, battery_mv, battery_low}
//   cfg      sink       APB write, pready = 1 full_scale_mv, low thresholds at 0x0/0x4/0x8
//
// One transaction is accepted per cycle while in_stall_o is low; each passes the ring stage
// register and then the scaling stage registers before out_valid_o rises.
// The sample ring memory is read at acceptance and written when the transaction leaves the
// ring stage; the next slot differs, so no interlock is needed for a window of two or more.
// After reset the ring is not cleared: a fill flag marks when every slot holds a sample.
// Under output stall the pipeline bubbles close up; in_stall_o rises only when all stages are full.
`default_nettype none

module battery_voltage_monitor
  import bvm_pkg::*;
#(
  parameter int WINDOW_LEN = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_t                   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_t                       out_data_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  localparam int PTR_W = $clog2(WINDOW_LEN);
  localparam int SUM_W = SAMPLE_W + PTR_W;

  cfg_t             cfg_q;
  logic             cfg_wr;
  reg_idx_e         reg_idx;
  logic             dn_valid;
  logic             dn_stall;
  logic [SUM_W-1:0] dn_total;
  ring_info_t       dn_info;

  // Register port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_scale_mv <= FULL_SCALE_RST;
      cfg_q.thr_run_mv    <= THR_RUN_RST;
      cfg_q.thr_idle_mv   <= THR_IDLE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FULL_SCALE: cfg_q.full_scale_mv <= pwdata[CFG_W-1:0];
        REG_THR_RUN:    cfg_q.thr_run_mv    <= pwdata[CFG_W-1:0];
        REG_THR_IDLE:   cfg_q.thr_idle_mv   <= pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      REG_FULL_SCALE: prdata = APB_DATA_W'(cfg_q.full_scale_mv);
      REG_THR_RUN:    prdata = APB_DATA_W'(cfg_q.thr_run_mv);
      REG_THR_IDLE:   prdata = APB_DATA_W'(cfg_q.thr_idle_mv);
      default:        prdata = '0;
    endcase
  end

  // Sample ring and running total.
  bvm_ring #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .dn_valid_o (dn_valid),
    .dn_stall_i (dn_stall),
    .dn_total_o (dn_total),
    .dn_info_o  (dn_info)
  );

  // Average, scaling and threshold compare.
  bvm_scale #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .up_valid_i  (dn_valid),
    .up_stall_o  (dn_stall),
    .up_total_i  (dn_total),
    .up_info_i   (dn_info),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
